>>> rtl/box_blur_3x3_edge_aware_core_defines.svh
// ----------------------------------------------------------------------------
// Box blur 3x3 assertion macros
// Shared concurrent assertion forms for the box blur checker.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AWARE_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while rst_cond is true
`define BB3_ASSERT_IMP(label, clk, rst_cond, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (rst_cond) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_cond is true
`define BB3_ASSERT_NXT(label, clk, rst_cond, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (rst_cond) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// Box blur 3x3 package
// Pixel, window column and control types plus fixed constants of the blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CSUM_W    = 10;  // three pixels of one channel
    localparam int SUM_W     = 12;  // nine pixels of one channel

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    // divisor classes after the power-of-two prescale
    localparam logic [1:0] DIV1 = 2'd0;
    localparam logic [1:0] DIV3 = 2'd1;
    localparam logic [1:0] DIV9 = 2'd2;

    // floor(2^16 / d) reciprocals
    localparam int RECIP_SHIFT = 16;
    localparam logic [15:0] RECIP3 = 16'd21845;
    localparam logic [15:0] RECIP9 = 16'd7281;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } pix_t;

    // one window column, top row first
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    typedef struct packed {
        logic [CSUM_W-1:0] r;
        logic [CSUM_W-1:0] g;
        logic [CSUM_W-1:0] b;
    } csum_t;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } sum_t;

    // which neighbors lie inside the frame, and the end-of-frame mark
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
        logic last;
    } nbr_t;

endpackage

>>> rtl/box_blur_3x3_edge_aware_core.sv
// ----------------------------------------------------------------------------
// Box blur 3x3 edge-aware core
// RGB raster-stream 3x3 box blur with frame-edge-aware rounded means.
// ----------------------------------------------------------------------------
// Takes one RGB beat per clock, unless the output stalls, in raster order
// and gives one blurred pixel per frame position, each channel the mean of
// the in-frame 3x3 neighbors rounded half up. Sustained rate is one beat per
// clock without output stalls: every beat reads the two-line store once at
// its column and writes it back from stage 1, and that single read/write
// pair per beat is what paces the block. The result for position p leaves
// after input p+W+1 has been accepted, through stage 1, the window, the
// divide stages and the output register; the first W+1 pixels of a frame
// give nothing. After the last pixel, send W+1 flush beats (action=1) to
// drain; the final result carries last_of_frame. A flush with nothing owed
// is dropped, a data beat during a drain starts a new frame, and any register
// write restarts the frame. Width and height are clamped to 1..MAX_WIDTH and
// 1..MAX_HEIGHT. The line store needs no reset clear: unwritten rows are masked.
module box_blur_3x3_edge_aware_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]     cfg_wdata,
    // pixel input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [bb3_pkg::PIX_W-1:0]     s_red_in,
    input  logic [bb3_pkg::PIX_W-1:0]     s_green_in,
    input  logic [bb3_pkg::PIX_W-1:0]     s_blue_in,
    // blurred output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bb3_pkg::PIX_W-1:0]     m_red_out,
    output logic [bb3_pkg::PIX_W-1:0]     m_green_out,
    output logic [bb3_pkg::PIX_W-1:0]     m_blue_out,
    output logic                          m_last_of_frame
);
    import bb3_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW     = $clog2(MAX_WIDTH + 1);
    localparam int EH     = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int PEND_W = $clog2(MAX_WIDTH + 2);
    localparam int LB_W   = 2 * $bits(pix_t);

    logic [CFG_W-1:0]  frame_width_reg;
    logic [CFG_W-1:0]  frame_height_reg;
    logic [EW-1:0]     eff_w;
    logic [EH-1:0]     eff_h;
    logic              cfg_hit;

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [PEND_W-1:0] pend_reg;

    logic              en;
    logic              acc;
    logic              is_data;
    logic              pend_nz;
    logic              restart;
    logic              proc;
    logic [COL_W-1:0]  c0;
    logic [ROW_W-1:0]  r0;
    logic [COL_W-1:0]  c;
    logic              emit_a;
    logic              emit_b;
    logic              wrap;
    logic [COL_W-1:0]  col_adv;
    logic [ROW_W-1:0]  row_adv;
    logic [PEND_W-1:0] pend_data;
    logic [PEND_W-1:0] pend_dec;
    nbr_t              nbr0;
    pix_t              px_in;

    logic              s1_vld_reg;
    logic              s1_emit_reg;
    pix_t              s1_px_reg;
    logic [COL_W-1:0]  s1_addr_reg;
    nbr_t              s1_nbr_reg;

    logic [LB_W-1:0]   lb_rd;
    col_t              new_col;
    col_t              col_q [3];
    csum_t             csum  [3];
    logic              shift;

    logic              s2_vld_reg;
    nbr_t              s2_nbr_reg;
    sum_t              win_sum;

    logic              mean_vld;
    pix_t              mean_pix;
    logic              mean_last;

    logic              m_valid_reg;
    pix_t              m_pix_reg;
    logic              m_last_reg;

    // configuration registers
    assign cfg_hit = cfg_we &&
                     ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= CFG_W'(RST_WIDTH);
            frame_height_reg <= CFG_W'(RST_HEIGHT);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamped frame size
    always_comb begin
        if (frame_width_reg == '0) begin
            eff_w = EW'(1);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            eff_h = EH'(1);
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            eff_h = EH'(MAX_HEIGHT);
        end else begin
            eff_h = EH'(frame_height_reg);
        end
    end

    // the whole pipeline moves while the output slot can take a beat
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign acc     = s_valid && en;

    // stream position and emit decision for the incoming beat
    always_comb begin
        is_data = !s_action;
        pend_nz = (pend_reg != '0);
        restart = is_data && (pend_nz || (32'(row_reg) >= 32'(eff_h)));
        proc    = is_data || pend_nz;
        c0      = restart ? '0 : col_reg;
        r0      = restart ? '0 : row_reg;
        c       = (32'(c0) >= 32'(eff_w)) ? '0 : c0;
        emit_a  = (c == '0) && (32'(r0) >= 32'd2);
        emit_b  = (c != '0) && (32'(r0) >= 32'd1);
        wrap    = (32'(c) + 32'd1) >= 32'(eff_w);
        col_adv = wrap ? '0 : COL_W'(32'(c) + 32'd1);
        row_adv = wrap ? ROW_W'(32'(r0) + 32'd1) : r0;
        pend_data = (32'(row_adv) >= 32'(eff_h)) ? PEND_W'(32'(eff_w) + 32'd1) : '0;
        pend_dec  = pend_reg - PEND_W'(1);

        // neighbors of the centre cell; the end of a row emits its last column
        nbr0.top   = emit_a ? (32'(r0) >= 32'd3) : (32'(r0) >= 32'd2);
        nbr0.bot   = emit_a ? ((32'(r0) - 32'd1) < 32'(eff_h)) : (32'(r0) < 32'(eff_h));
        nbr0.left  = emit_a ? (32'(eff_w) >= 32'd2) : (32'(c) >= 32'd2);
        nbr0.right = !emit_a;
        nbr0.last  = !is_data && (pend_dec == '0);

        px_in.r = s_red_in;
        px_in.g = s_green_in;
        px_in.b = s_blue_in;
    end

    // position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end else if (cfg_hit) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end else if (acc && proc) begin
            if (is_data) begin
                col_reg  <= col_adv;
                row_reg  <= row_adv;
                pend_reg <= pend_data;
            end else begin
                pend_reg <= pend_dec;
                if (pend_dec == '0) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else begin
                    col_reg <= col_adv;
                    row_reg <= row_adv;
                end
            end
        end
    end

    // stage 1: line store read in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= acc && proc;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && proc) begin
            s1_px_reg   <= is_data ? px_in : '0;
            s1_addr_reg <= c;
            s1_emit_reg <= emit_a || emit_b;
            s1_nbr_reg  <= nbr0;
        end
    end

    // two lines above, packed {upper, middle} per column
    bb3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W),
        .DW    (LB_W)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (acc && proc),
        .rd_addr (c),
        .wr_en   (shift),
        .wr_addr (s1_addr_reg),
        .wr_data ({lb_rd[$bits(pix_t)-1:0], s1_px_reg}),
        .rd_data (lb_rd)
    );

    // window: three column cells, newest on the right
    assign shift       = en && s1_vld_reg;
    assign new_col.top = lb_rd[LB_W-1:$bits(pix_t)];
    assign new_col.mid = lb_rd[$bits(pix_t)-1:0];
    assign new_col.bot = s1_px_reg;

    bb3_col_cell u_cell2 (
        .aclk    (aclk),
        .shift   (shift),
        .col_in  (new_col),
        .nbr     (s2_nbr_reg),
        .col_out (col_q[2]),
        .sum_out (csum[2])
    );

    bb3_col_cell u_cell1 (
        .aclk    (aclk),
        .shift   (shift),
        .col_in  (col_q[2]),
        .nbr     (s2_nbr_reg),
        .col_out (col_q[1]),
        .sum_out (csum[1])
    );

    bb3_col_cell u_cell0 (
        .aclk    (aclk),
        .shift   (shift),
        .col_in  (col_q[1]),
        .nbr     (s2_nbr_reg),
        .col_out (col_q[0]),
        .sum_out (csum[0])
    );

    // stage 2: window holds the neighborhood of an emitting beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            s2_nbr_reg <= s1_nbr_reg;
        end
    end

    // row of column sums, edge columns masked
    always_comb begin
        win_sum.r = SUM_W'(csum[1].r)
                  + (s2_nbr_reg.left  ? SUM_W'(csum[0].r) : '0)
                  + (s2_nbr_reg.right ? SUM_W'(csum[2].r) : '0);
        win_sum.g = SUM_W'(csum[1].g)
                  + (s2_nbr_reg.left  ? SUM_W'(csum[0].g) : '0)
                  + (s2_nbr_reg.right ? SUM_W'(csum[2].g) : '0);
        win_sum.b = SUM_W'(csum[1].b)
                  + (s2_nbr_reg.left  ? SUM_W'(csum[0].b) : '0)
                  + (s2_nbr_reg.right ? SUM_W'(csum[2].b) : '0);
    end

    bb3_mean u_mean (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s2_vld_reg),
        .in_sum   (win_sum),
        .in_nbr   (s2_nbr_reg),
        .out_vld  (mean_vld),
        .out_pix  (mean_pix),
        .out_last (mean_last)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= mean_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && mean_vld) begin
            m_pix_reg  <= mean_pix;
            m_last_reg <= mean_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_red_out       = m_pix_reg.r;
    assign m_green_out     = m_pix_reg.g;
    assign m_blue_out      = m_pix_reg.b;
    assign m_last_of_frame = m_last_reg;

endmodule

>>> rtl/bb3_line_buf.sv
// ----------------------------------------------------------------------------
// Box blur line buffer
// One-read one-write memory with registered read and write-to-read forwarding.
// ----------------------------------------------------------------------------
module bb3_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 48
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port; a same-address write in this cycle is forwarded
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bb3_col_cell.sv
// ----------------------------------------------------------------------------
// Box blur window column cell
// Holds one column of the 3x3 window, passes it on at each shift and gives
// the per-channel sum of the rows that lie inside the frame.
// ----------------------------------------------------------------------------
module bb3_col_cell (
    input  logic          aclk,
    input  logic          shift,
    input  bb3_pkg::col_t col_in,
    input  bb3_pkg::nbr_t nbr,
    output bb3_pkg::col_t col_out,
    output bb3_pkg::csum_t sum_out
);
    import bb3_pkg::*;

    col_t col_reg;

    // column register, loaded from the neighbor on each shift
    always_ff @(posedge aclk) begin
        if (shift) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    // masked column sum
    always_comb begin
        sum_out.r = CSUM_W'(col_reg.mid.r)
                  + (nbr.top ? CSUM_W'(col_reg.top.r) : '0)
                  + (nbr.bot ? CSUM_W'(col_reg.bot.r) : '0);
        sum_out.g = CSUM_W'(col_reg.mid.g)
                  + (nbr.top ? CSUM_W'(col_reg.top.g) : '0)
                  + (nbr.bot ? CSUM_W'(col_reg.bot.g) : '0);
        sum_out.b = CSUM_W'(col_reg.mid.b)
                  + (nbr.top ? CSUM_W'(col_reg.top.b) : '0)
                  + (nbr.bot ? CSUM_W'(col_reg.bot.b) : '0);
    end

endmodule

>>> rtl/bb3_mean.sv
// ----------------------------------------------------------------------------
// Box blur rounded mean
// Three-stage divide of the window sums by the neighbor count, rounding
// half up: prescale by a power of two, reciprocal multiply, then correct.
// ----------------------------------------------------------------------------
module bb3_mean (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_vld,
    input  bb3_pkg::sum_t  in_sum,
    input  bb3_pkg::nbr_t  in_nbr,
    output logic           out_vld,
    output bb3_pkg::pix_t  out_pix,
    output logic           out_last
);
    import bb3_pkg::*;

    localparam int X_W    = SUM_W + 1;
    localparam int PROD_W = SUM_W + RECIP_SHIFT;

    logic [1:0]       rows;
    logic [1:0]       cols;
    logic [3:0]       cnt;
    logic [1:0]       sh;
    logic [1:0]       code;
    logic [SUM_W-1:0] s_in [3];
    logic [X_W-1:0]   x    [3];
    logic [SUM_W-1:0] y    [3];

    logic             a_vld_reg;
    logic             a_last_reg;
    logic [1:0]       a_code_reg;
    logic [SUM_W-1:0] a_y_reg [3];

    logic [15:0]       recip;
    logic [PROD_W-1:0] prod [3];

    logic             b_vld_reg;
    logic             b_last_reg;
    logic [1:0]       b_code_reg;
    logic [SUM_W-1:0] b_y_reg  [3];
    logic [SUM_W-1:0] b_q0_reg [3];

    logic [SUM_W+3:0] q0d  [3];
    logic [SUM_W+3:0] rem  [3];
    logic [SUM_W+3:0] dval;
    logic [SUM_W-1:0] q    [3];

    // stage A: count, 2*s + n, power-of-two prescale
    always_comb begin
        rows = 2'd1 + {1'b0, in_nbr.top} + {1'b0, in_nbr.bot};
        cols = 2'd1 + {1'b0, in_nbr.left} + {1'b0, in_nbr.right};
        cnt  = {2'b00, rows} * {2'b00, cols};
        case (cnt)
            4'd1:    begin sh = 2'd1; code = DIV1; end
            4'd2:    begin sh = 2'd2; code = DIV1; end
            4'd4:    begin sh = 2'd3; code = DIV1; end
            4'd3:    begin sh = 2'd1; code = DIV3; end
            4'd6:    begin sh = 2'd2; code = DIV3; end
            4'd9:    begin sh = 2'd1; code = DIV9; end
            default: begin sh = 2'd1; code = DIV1; end
        endcase
        s_in[0] = in_sum.r;
        s_in[1] = in_sum.g;
        s_in[2] = in_sum.b;
        for (int ch = 0; ch < 3; ch++) begin
            x[ch] = {s_in[ch], 1'b0} + X_W'(cnt);
            y[ch] = SUM_W'(x[ch] >> sh);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_vld) begin
            a_last_reg <= in_nbr.last;
            a_code_reg <= code;
            for (int ch = 0; ch < 3; ch++) begin
                a_y_reg[ch] <= y[ch];
            end
        end
    end

    // stage B: reciprocal multiply, estimate low by at most one
    always_comb begin
        case (a_code_reg)
            DIV3:    recip = RECIP3;
            DIV9:    recip = RECIP9;
            default: recip = '0;
        endcase
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PROD_W'(a_y_reg[ch]) * PROD_W'(recip);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && a_vld_reg) begin
            b_last_reg <= a_last_reg;
            b_code_reg <= a_code_reg;
            for (int ch = 0; ch < 3; ch++) begin
                b_y_reg[ch] <= a_y_reg[ch];
                if (a_code_reg == DIV1) begin
                    b_q0_reg[ch] <= a_y_reg[ch];
                end else begin
                    b_q0_reg[ch] <= prod[ch][PROD_W-1:RECIP_SHIFT];
                end
            end
        end
    end

    // stage C: remainder check and bump
    always_comb begin
        case (b_code_reg)
            DIV3:    dval = (SUM_W+4)'(3);
            DIV9:    dval = (SUM_W+4)'(9);
            default: dval = (SUM_W+4)'(1);
        endcase
        for (int ch = 0; ch < 3; ch++) begin
            case (b_code_reg)
                DIV3:    q0d[ch] = ((SUM_W+4)'(b_q0_reg[ch]) << 1) + (SUM_W+4)'(b_q0_reg[ch]);
                DIV9:    q0d[ch] = ((SUM_W+4)'(b_q0_reg[ch]) << 3) + (SUM_W+4)'(b_q0_reg[ch]);
                default: q0d[ch] = (SUM_W+4)'(b_q0_reg[ch]);
            endcase
            rem[ch] = (SUM_W+4)'(b_y_reg[ch]) - q0d[ch];
            q[ch]   = (rem[ch] >= dval) ? b_q0_reg[ch] + SUM_W'(1) : b_q0_reg[ch];
        end
    end

    assign out_vld   = b_vld_reg;
    assign out_last  = b_last_reg;
    assign out_pix.r = PIX_W'(q[0]);
    assign out_pix.g = PIX_W'(q[1]);
    assign out_pix.b = PIX_W'(q[2]);

endmodule

>>> rtl/bb3_checker.sv
// ----------------------------------------------------------------------------
// Box blur port checker
// Watches the core's ports for output handshake and flow-control slips.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_aware_core_defines.svh"

module bb3_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_we,
    input logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [bb3_pkg::CFG_W-1:0]     cfg_wdata,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_action,
    input logic [bb3_pkg::PIX_W-1:0]     s_red_in,
    input logic [bb3_pkg::PIX_W-1:0]     s_green_in,
    input logic [bb3_pkg::PIX_W-1:0]     s_blue_in,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bb3_pkg::PIX_W-1:0]     m_red_out,
    input logic [bb3_pkg::PIX_W-1:0]     m_green_out,
    input logic [bb3_pkg::PIX_W-1:0]     m_blue_out,
    input logic                          m_last_of_frame
);

    // a stalled result beat stays offered
    `BB3_ASSERT_NXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready, m_valid, "result beat dropped while stalled")

    // and keeps its payload
    `BB3_ASSERT_NXT(a_out_stable, aclk, !aresetn, m_valid && !m_ready, $stable(m_red_out) && $stable(m_green_out) && $stable(m_blue_out) && $stable(m_last_of_frame), "result payload changed while stalled")

    // a blocked output slot must hold off the input side
    `BB3_ASSERT_IMP(a_stall_blocks_in, aclk, !aresetn, m_valid && !m_ready, !s_ready, "input taken while output slot blocked")

    // reset empties the output slot
    `BB3_ASSERT_NXT(a_reset_idle, aclk, 1'b0, !aresetn, !m_valid, "result offered right after reset")

endmodule

bind box_blur_3x3_edge_aware_core bb3_checker u_bb3_checker (.*);

>>> tb/bb3_tb_pkg.sv
// ----------------------------------------------------------------------------
// Box blur 3x3 testbench codes
// Beat action codes shared by the stimulus and the result checker.
// ----------------------------------------------------------------------------
package bb3_tb_pkg;

    // s_action values
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

endpackage

>>> tb/bb3_blur_check.sv
// ----------------------------------------------------------------------------
// Box blur 3x3 result checker
// Follows register writes and accepted pixel beats, computes the blurred
// pixel each beat should produce and compares every result beat against the
// oldest one still owed.
// ----------------------------------------------------------------------------
module bb3_blur_check
    import bb3_pkg::*;
    import bb3_tb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_action,
    input  logic [PIX_W-1:0]     s_red_in,
    input  logic [PIX_W-1:0]     s_green_in,
    input  logic [PIX_W-1:0]     s_blue_in,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [PIX_W-1:0]     m_red_out,
    input  logic [PIX_W-1:0]     m_green_out,
    input  logic [PIX_W-1:0]     m_blue_out,
    input  logic                 m_last_of_frame,
    output int                   mismatch_total,
    output int                   owed_count,
    output int                   pixels_checked
);

    localparam int REPORT_CAP = 200;

    typedef struct packed {
        pix_t px;
        logic last;
    } blur_res_t;

    // shadow of the block: two line stores, the 3x3 window and the position
    pix_t             upper_line [MAX_WIDTH];
    pix_t             middle_line [MAX_WIDTH];
    pix_t             win [9];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      flush_owed;

    blur_res_t        owed_pixels [$];
    int               errs = 0;
    int               seen = 0;

    initial begin
        mismatch_total = 0;
        owed_count     = 0;
        pixels_checked = 0;
    end

    function automatic int unsigned dim_used(logic [CFG_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // rounded mean around window row 1, column wc; that cell sits at (crow, ccol)
    function automatic pix_t window_mean(int wc, int crow, int ccol);
        int          w, h, fr, fc, k, i, j;
        int unsigned sr, sg, sb, cnt;
        pix_t        nb, avg;
        w   = int'(dim_used(width_reg, MAX_WIDTH));
        h   = int'(dim_used(height_reg, MAX_HEIGHT));
        sr  = 0;
        sg  = 0;
        sb  = 0;
        cnt = 0;
        for (i = 0; i < 3; i++) begin
            fr = crow - 1 + i;
            if (fr >= 0 && fr < h) begin
                for (j = 0; j < 3; j++) begin
                    k  = wc - 1 + j;
                    fc = ccol - 1 + j;
                    // only neighbors inside the frame count toward the mean
                    if (k >= 0 && k <= 2 && fc >= 0 && fc < w) begin
                        nb  = win[i*3 + k];
                        sr += nb.r;
                        sg += nb.g;
                        sb += nb.b;
                        cnt++;
                    end
                end
            end
        end
        // round to nearest, ties go up
        avg.r = 8'((2*sr + cnt) / (2*cnt));
        avg.g = 8'((2*sg + cnt) / (2*cnt));
        avg.b = 8'((2*sb + cnt) / (2*cnt));
        return avg;
    endfunction

    // one stream position: shift the window, maybe close out a pixel
    function automatic bit advance_position(pix_t px, output pix_t mean);
        int unsigned w, c, r;
        pix_t        up, mid;
        bit          got;
        w    = dim_used(width_reg, MAX_WIDTH);
        c    = (col_pos >= w) ? 0 : col_pos;
        r    = row_pos;
        got  = 1'b0;
        mean = '0;
        // column zero finishes the last pixel of the row two above
        if (c == 0 && r >= 2) begin
            mean = window_mean(2, int'(r) - 2, int'(w) - 1);
            got  = 1'b1;
        end
        up             = upper_line[c];
        mid            = middle_line[c];
        upper_line[c]  = mid;
        middle_line[c] = px;
        win[0] = win[1];  win[1] = win[2];  win[2] = up;
        win[3] = win[4];  win[4] = win[5];  win[5] = mid;
        win[6] = win[7];  win[7] = win[8];  win[8] = px;
        if (c != 0 && r >= 1) begin
            mean = window_mean(1, int'(r) - 1, int'(c) - 1);
            got  = 1'b1;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
        return got;
    endfunction

    // expected result of one accepted input beat
    function automatic bit blur_step(logic act, pix_t px, output blur_res_t res);
        int unsigned h;
        bit          got;
        pix_t        mean;
        h    = dim_used(height_reg, MAX_HEIGHT);
        res  = '0;
        got  = 1'b0;
        mean = '0;
        if (act == ACT_PIXEL) begin
            // a pixel during a drain or after a full frame opens a new frame
            if (flush_owed != 0 || row_pos >= h) begin
                col_pos    = 0;
                row_pos    = 0;
                flush_owed = 0;
            end
            got = advance_position(px, mean);
            if (row_pos >= h) flush_owed = dim_used(width_reg, MAX_WIDTH) + 1;
        end else if (flush_owed != 0) begin
            got = advance_position('0, mean);
            flush_owed--;
            if (flush_owed == 0) begin
                res.last = got;
                col_pos  = 0;
                row_pos  = 0;
            end
        end
        res.px = mean;
        return got;
    endfunction

    // track config, predict, compare
    always @(posedge aclk) begin
        blur_res_t want, fresh;
        if (!aresetn) begin
            width_reg  = CFG_W'(RST_WIDTH);
            height_reg = CFG_W'(RST_HEIGHT);
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            flush_owed = 0;
            owed_pixels.delete();
        end else begin
            // result beat against the oldest owed pixel
            if (m_valid && m_ready) begin
                seen++;
                if (owed_pixels.size() == 0) begin
                    errs++;
                    if (errs <= REPORT_CAP)
                        $display("%0t ERROR: result beat, expected none, got %0d/%0d/%0d last %0b",
                                 $time, m_red_out, m_green_out, m_blue_out, m_last_of_frame);
                end else begin
                    want = owed_pixels.pop_front();
                    if (m_red_out !== want.px.r) begin
                        errs++;
                        if (errs <= REPORT_CAP)
                            $display("%0t ERROR: red_out expected %0d, got %0d",
                                     $time, want.px.r, m_red_out);
                    end
                    if (m_green_out !== want.px.g) begin
                        errs++;
                        if (errs <= REPORT_CAP)
                            $display("%0t ERROR: green_out expected %0d, got %0d",
                                     $time, want.px.g, m_green_out);
                    end
                    if (m_blue_out !== want.px.b) begin
                        errs++;
                        if (errs <= REPORT_CAP)
                            $display("%0t ERROR: blue_out expected %0d, got %0d",
                                     $time, want.px.b, m_blue_out);
                    end
                    if (m_last_of_frame !== want.last) begin
                        errs++;
                        if (errs <= REPORT_CAP)
                            $display("%0t ERROR: last_of_frame expected %0b, got %0b",
                                     $time, want.last, m_last_of_frame);
                    end
                end
                if (errs > REPORT_CAP && errs - REPORT_CAP <= 4)
                    $display("%0t further mismatch reports suppressed", $time);
            end

            // any register write restarts the frame
            if (cfg_we) begin
                if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_wdata;
                else height_reg = cfg_wdata;
                col_pos    = 0;
                row_pos    = 0;
                flush_owed = 0;
            end

            if (s_valid && s_ready) begin
                if (blur_step(s_action, {s_red_in, s_green_in, s_blue_in}, fresh))
                    owed_pixels.push_back(fresh);
            end
        end
        mismatch_total <= errs;
        owed_count     <= owed_pixels.size();
        pixels_checked <= seen;
    end

endmodule

>>> tb/tb_box_blur_3x3_edge_aware_core.sv
// ----------------------------------------------------------------------------
// Box blur 3x3 edge-aware core testbench
// Drives framed pixel streams with flush drains through the core under many
// frame sizes, with random sender gaps and receiver stalls; a side checker
// predicts every blurred pixel and this top reports the verdict.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_aware_core;
    import bb3_pkg::*;
    import bb3_tb_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam int TOTAL_ITEMS  = 1750;
    localparam int WIDE_FLUSHES = 150;
    localparam int TALL_ROWS    = 64;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 400;
    localparam int QUIET_LIMIT  = 5000;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_CHOKED, SINK_PERIODIC} sink_mode_e;
    typedef enum int {FRM_WHOLE, FRM_SHORT_DRAIN, FRM_EXTRA_FLUSH, FRM_NO_FLUSH, FRM_CUT}
        frame_kind_e;

    // corner, edge and center probes at full scale and near zero
    localparam logic [23:0] PROBE_PX [9] = '{
        24'hFFFFFF, 24'h000000, 24'hFF0001,
        24'h00FF80, 24'hFFFFFF, 24'h0100FE,
        24'h7F80FF, 24'h000000, 24'hFFFF00
    };

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic               s_action;
    logic [PIX_W-1:0]   s_red_in;
    logic [PIX_W-1:0]   s_green_in;
    logic [PIX_W-1:0]   s_blue_in;
    logic               m_valid;
    logic               m_ready;
    logic [PIX_W-1:0]   m_red_out;
    logic [PIX_W-1:0]   m_green_out;
    logic [PIX_W-1:0]   m_blue_out;
    logic               m_last_of_frame;

    int                 mismatch_total;
    int                 owed_count;
    int                 pixels_checked;

    int                 hold_ticket = 0;
    int                 burst_left  = 0;
    int                 beats_fed   = 0;
    int                 settings_cnt = 0;
    int unsigned        cur_w = RST_WIDTH;
    int unsigned        cur_h = RST_HEIGHT;

    always #4 aclk = ~aclk;

    box_blur_3x3_edge_aware_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_last_of_frame (m_last_of_frame)
    );

    bb3_blur_check #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) blur_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_last_of_frame (m_last_of_frame),
        .mismatch_total  (mismatch_total),
        .owed_count      (owed_count),
        .pixels_checked  (pixels_checked)
    );

    function automatic int unsigned dim_used(logic [CFG_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // channel value biased toward the extremes
    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic pix_t rand_pixel();
        pix_t p;
        p.r = pick_level();
        p.g = pick_level();
        p.b = pick_level();
        return p;
    endfunction

    // one input beat; bursts of random length with random gaps between them
    task automatic push_beat(input logic act, input pix_t px);
        int gap_len;
        if (burst_left == 0) begin
            gap_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                                  : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(64, 256)
                                                     : $urandom_range(1, 24);
            if (gap_len != 0) begin
                s_valid <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_red_in   <= px.r;
        s_green_in <= px.g;
        s_blue_in  <= px.b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        beats_fed++;
    endtask

    // random pixels, an odd stray flush among them, then flush beats
    task automatic send_stream(input int unsigned npix, input int unsigned nflush);
        int unsigned i;
        for (i = 0; i < npix; i++) begin
            if ($urandom_range(0, 39) == 0) push_beat(ACT_FLUSH, rand_pixel());
            push_beat(ACT_PIXEL, rand_pixel());
        end
        for (i = 0; i < nflush; i++) push_beat(ACT_FLUSH, rand_pixel());
    endtask

    // hold the sender until every owed result is out and the pipe is empty
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (owed_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
                            input bit both);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, wv);
        cur_w = dim_used(wv, MAX_W);
        if (both) begin
            write_reg(REG_FRAME_HEIGHT, hv);
            cur_h = dim_used(hv, MAX_H);
        end
        settings_cnt++;
    endtask

    // result side: stall patterns of its own, plus a long hold on request
    initial begin : result_sink
        sink_mode_e mode;
        int         run_left, hold_served, phase;
        mode        = SINK_OPEN;
        run_left    = 0;
        hold_served = 0;
        phase       = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_ticket != hold_served) begin
                hold_served = hold_ticket;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    mode     = sink_mode_e'($urandom_range(0, 3));
                    run_left = $urandom_range(16, 160);
                end
                run_left--;
                phase++;
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    SINK_CHOKED: m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= ((phase % 7) < 4);
                endcase
            end
        end
    end

    // watchdog: too long without any beat moving on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t ERROR: no beat moved for %0d cycles", $time, quiet);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned wv, hv, nframes, f, i, npix;
        frame_kind_e kind;
        bit          cut;
        s_valid    <= 1'b0;
        s_action   <= ACT_PIXEL;
        s_red_in   <= '0;
        s_green_in <= '0;
        s_blue_in  <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_wdata  <= '0;
        aresetn    <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stray flush straight after reset: nothing owed, dropped
        push_beat(ACT_FLUSH, pix_t'(24'h5A5A5A));

        // 3x3 frame of extreme values, full drain plus one surplus flush
        set_dims(11'd3, 11'd3, 1'b1);
        for (i = 0; i < 9; i++) push_beat(ACT_PIXEL, pix_t'(PROBE_PX[i]));
        for (i = 0; i < 5; i++) push_beat(ACT_FLUSH, rand_pixel());

        // single row via zero height; half-way means round up
        set_dims(11'd2, 11'd0, 1'b1);
        push_beat(ACT_PIXEL, pix_t'(24'h0001FF));
        push_beat(ACT_PIXEL, pix_t'(24'h0100FE));
        for (i = 0; i < 3; i++) push_beat(ACT_FLUSH, rand_pixel());

        // widest line clamped from the top value, part of the drain with the
        // output held off; the next register write abandons the rest
        set_dims(11'd2047, 11'd0, 1'b1);
        send_stream(cur_w, 0);
        hold_ticket <= hold_ticket + 1;
        send_stream(0, WIDE_FLUSHES);

        // one pixel wide, tall frame
        set_dims(11'd0, CFG_W'(TALL_ROWS), 1'b1);
        send_stream(cur_w * cur_h, cur_w + 1);

        // random sizes: mostly complete frames, some broken drains and cut frames
        while (beats_fed < TOTAL_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       wv = 0;
                1:       wv = $urandom_range(1025, 2047);
                2:       wv = 1024;
                3, 4, 5: wv = $urandom_range(9, 40);
                default: wv = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 19))
                0:       hv = 0;
                1:       hv = $urandom_range(1025, 2047);
                2:       hv = 1024;
                3, 4:    hv = $urandom_range(9, 24);
                default: hv = $urandom_range(1, 6);
            endcase
            set_dims(CFG_W'(wv), CFG_W'(hv), $urandom_range(0, 3) != 0);
            nframes = $urandom_range(1, 4);
            cut     = 1'b0;
            for (f = 0; f < nframes && !cut && beats_fed < TOTAL_ITEMS; f++) begin
                if (cur_w * cur_h > 400) kind = FRM_CUT;
                else begin
                    case ($urandom_range(0, 9))
                        0:       kind = FRM_SHORT_DRAIN;
                        1:       kind = FRM_EXTRA_FLUSH;
                        2:       kind = FRM_NO_FLUSH;
                        3:       kind = FRM_CUT;
                        default: kind = FRM_WHOLE;
                    endcase
                end
                if ($urandom_range(0, 29) == 0) hold_ticket <= hold_ticket + 1;
                npix = cur_w * cur_h;
                case (kind)
                    FRM_WHOLE:       send_stream(npix, cur_w + 1);
                    FRM_SHORT_DRAIN: send_stream(npix, $urandom_range(0, cur_w));
                    FRM_EXTRA_FLUSH: send_stream(npix, cur_w + 1 + $urandom_range(1, 3));
                    FRM_NO_FLUSH:    send_stream(npix, 0);
                    default: begin
                        // frame left unfinished; the next register write abandons it
                        send_stream($urandom_range(1, (npix > 80) ? 80 : npix),
                                    $urandom_range(0, 2));
                        cut = 1'b1;
                    end
                endcase
            end
        end

        wait_drained();
        $display("Covered %0d input beats over %0d frame size settings, widths and heights",
                 beats_fed, settings_cnt);
        $display("from 1 to 1024 with out-of-range values; %0d blurred pixels checked.",
                 pixels_checked);
        if (mismatch_total == 0 && owed_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> box_blur_3x3_edge_aware_core.f
+incdir+rtl
rtl/bb3_pkg.sv
rtl/bb3_line_buf.sv
rtl/bb3_col_cell.sv
rtl/bb3_mean.sv
rtl/box_blur_3x3_edge_aware_core.sv
rtl/bb3_checker.sv
tb/bb3_tb_pkg.sv
tb/bb3_blur_check.sv
tb/tb_box_blur_3x3_edge_aware_core.sv
